// ===== rtl/core/digit_dominance_prefix_count_macros.svh =====
// ----------------------------------------------------------------------------
// digit_dominance_prefix_count assertion macros
// Clocked, reset-gated property wrappers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef DIGIT_DOMINANCE_PREFIX_COUNT_MACROS_SVH
`define DIGIT_DOMINANCE_PREFIX_COUNT_MACROS_SVH

// same-cycle implication
`define DDPC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define DDPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/ddpc_pkg.sv =====
// ----------------------------------------------------------------------------
// ddpc_pkg
// Shared constants for the digit dominance prefix counter.
// ----------------------------------------------------------------------------
`default_nettype none
package ddpc_pkg;
    localparam int MAX_DIGITS_DEF = 64;
    localparam int BASE_BITS_DEF  = 16;
    localparam int VAL_BITS       = 64;
    localparam int BASE_RESET     = 2;
endpackage
`default_nettype wire

// ===== rtl/core/digit_dominance_prefix_count.sv =====
// ----------------------------------------------------------------------------
// digit_dominance_prefix_count
// Counts x below n whose base-p digits never exceed those of m, and the rest of [0, n).
// ----------------------------------------------------------------------------
// Usage:
//   Input request (i_bound_m, i_limit_n) is taken when i_in_valid is high
//   and o_in_stall is low. o_in_stall is high while a request is in work.
//   Base p is written through i_cfg_we / i_cfg_data while idle; 0 and 1
//   act as 2. Reset sets the base to 2 and empties the block.
//   Per digit position, two lockstep shift-subtract dividers produce the
//   digits of n-1 and m, then a shift-add multiplier forms the count term
//   and next weight. Digits run from the bottom up until both quotients
//   reach zero or MAX_DIGITS are done. One request at a time.
//   The result sits in an output register (o_out_valid); if the receiver
//   stalls, the result holds and a finished next result waits in the
//   core until the register is free.
// ----------------------------------------------------------------------------
`default_nettype none
module digit_dominance_prefix_count #(
    parameter int MAX_DIGITS = ddpc_pkg::MAX_DIGITS_DEF,
    parameter int BASE_BITS  = ddpc_pkg::BASE_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [BASE_BITS-1:0] i_cfg_data,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic [63:0]          i_bound_m,
    input  wire logic [63:0]          i_limit_n,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic [63:0]               o_hit_count,
    output logic [63:0]               o_dominated_count
);
    `include "digit_dominance_prefix_count_macros.svh"

    localparam int VB = ddpc_pkg::VAL_BITS;
    localparam int MW = $clog2(BASE_BITS + 2);
    localparam int DW = $clog2(MAX_DIGITS + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_MUL  = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [1:0]           r_state, n_state;
    logic [BASE_BITS-1:0] r_base;
    logic [BASE_BITS-1:0] base_eff;
    logic [VB-1:0]        r_y, n_y, r_m, n_m, r_n, n_n;
    logic [BASE_BITS-1:0] r_y_rem, n_y_rem, r_m_rem, n_m_rem;
    logic [5:0]           r_cnt, n_cnt;
    logic [MW-1:0]        r_mcnt, n_mcnt;
    logic [DW-1:0]        r_dig, n_dig;
    logic [BASE_BITS:0]   r_mc, n_mc, r_mf, n_mf;
    logic [VB-1:0]        r_ma, n_ma, r_pc, n_pc, r_pw, n_pw;
    logic [VB-1:0]        r_acc, n_acc, r_w, n_w;
    logic                 r_gt, n_gt, r_zero, n_zero;
    logic                 r_ov, n_ov;
    logic [VB-1:0]        r_hit, n_hit, r_dom, n_dom;
    logic                 in_acc;
    logic [BASE_BITS:0]   y_sh, m_sh, y_dif, m_dif, mi1;
    logic                 y_ge, m_ge;
    logic [VB-1:0]        dom_fin, pc_fin, pw_fin;

    assign base_eff = (r_base < BASE_BITS'(2)) ? BASE_BITS'(2) : r_base;
    assign in_acc   = i_in_valid && !o_in_stall;

    // lockstep shift-subtract divider steps, one per operand
    assign y_sh  = {r_y_rem, r_y[VB-1]};
    assign m_sh  = {r_m_rem, r_m[VB-1]};
    assign y_dif = y_sh - {1'b0, base_eff};
    assign m_dif = m_sh - {1'b0, base_eff};
    assign y_ge  = y_sh >= {1'b0, base_eff};
    assign m_ge  = m_sh >= {1'b0, base_eff};

    // shift-add multiplier final step values
    assign pc_fin  = r_mc[0] ? r_pc + r_ma : r_pc;
    assign pw_fin  = r_mf[0] ? r_pw + r_ma : r_pw;
    assign dom_fin = r_zero ? '0 : r_acc;

    always_comb begin
        n_state = r_state; n_y = r_y; n_m = r_m; n_n = r_n;
        n_y_rem = r_y_rem; n_m_rem = r_m_rem; n_cnt = r_cnt; n_mcnt = r_mcnt;
        n_dig = r_dig; n_mc = r_mc; n_mf = r_mf; n_ma = r_ma; n_pc = r_pc;
        n_pw = r_pw; n_acc = r_acc; n_w = r_w; n_gt = r_gt; n_zero = r_zero;
        n_ov = r_ov; n_hit = r_hit; n_dom = r_dom;
        mi1 = '0;
        if (r_ov && !i_out_stall) begin
            n_ov = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_n     = i_limit_n;
                    n_y     = i_limit_n - VB'(1);
                    n_m     = i_bound_m;
                    n_zero  = (i_limit_n == '0);
                    n_acc   = VB'(1);
                    n_w     = VB'(1);
                    n_dig   = '0;
                    n_cnt   = '0;
                    n_y_rem = '0;
                    n_m_rem = '0;
                    n_state = (i_limit_n == '0) ? ST_FIN : ST_DIV;
                end
            end
            ST_DIV: begin
                n_y     = {r_y[VB-2:0], y_ge};
                n_m     = {r_m[VB-2:0], m_ge};
                n_y_rem = y_ge ? y_dif[BASE_BITS-1:0] : y_sh[BASE_BITS-1:0];
                n_m_rem = m_ge ? m_dif[BASE_BITS-1:0] : m_sh[BASE_BITS-1:0];
                n_cnt   = r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    // digits ready: set up the two products
                    mi1     = {1'b0, n_m_rem} + (BASE_BITS+1)'(1);
                    n_gt    = n_y_rem > n_m_rem;
                    n_mc    = ({1'b0, n_y_rem} < mi1) ? {1'b0, n_y_rem} : mi1;
                    n_mf    = mi1;
                    n_ma    = r_w;
                    n_pc    = '0;
                    n_pw    = '0;
                    n_mcnt  = '0;
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_pc   = pc_fin;
                n_pw   = pw_fin;
                n_ma   = {r_ma[VB-2:0], 1'b0};
                n_mc   = r_mc >> 1;
                n_mf   = r_mf >> 1;
                n_mcnt = r_mcnt + MW'(1);
                if (r_mcnt == MW'(BASE_BITS)) begin
                    // fold this digit into the running count
                    n_acc   = pc_fin + (r_gt ? '0 : r_acc);
                    n_w     = pw_fin;
                    n_dig   = r_dig + DW'(1);
                    n_cnt   = '0;
                    n_y_rem = '0;
                    n_m_rem = '0;
                    if (r_dig == DW'(MAX_DIGITS - 1) || (r_y == '0 && r_m == '0)) begin
                        n_state = ST_FIN;
                    end else begin
                        n_state = ST_DIV;
                    end
                end
            end
            ST_FIN: begin
                if (!r_ov || !i_out_stall) begin
                    n_ov    = 1'b1;
                    n_dom   = dom_fin;
                    n_hit   = r_n - dom_fin;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ov    <= 1'b0;
            r_base  <= BASE_BITS'(ddpc_pkg::BASE_RESET);
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
            if (i_cfg_we) begin
                r_base <= i_cfg_data;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_y <= n_y; r_m <= n_m; r_n <= n_n;
        r_y_rem <= n_y_rem; r_m_rem <= n_m_rem;
        r_cnt <= n_cnt; r_mcnt <= n_mcnt; r_dig <= n_dig;
        r_mc <= n_mc; r_mf <= n_mf; r_ma <= n_ma; r_pc <= n_pc; r_pw <= n_pw;
        r_acc <= n_acc; r_w <= n_w; r_gt <= n_gt; r_zero <= n_zero;
        r_hit <= n_hit; r_dom <= n_dom;
    end

    assign o_in_stall        = (r_state != ST_IDLE);
    assign o_out_valid       = r_ov;
    assign o_hit_count       = r_hit;
    assign o_dominated_count = r_dom;

    `DDPC_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, in_acc, r_state != ST_IDLE)
    `DDPC_ASSERT_NOW(a_rem_below_base, i_clk, i_rst_n, r_state == ST_MUL, (r_y_rem < base_eff) && (r_m_rem < base_eff))
    `DDPC_ASSERT_NOW(a_digit_bound, i_clk, i_rst_n, r_state == ST_DIV || r_state == ST_MUL, r_dig < DW'(MAX_DIGITS))
    `DDPC_ASSERT_NEXT(a_out_drain, i_clk, i_rst_n, r_ov && !i_out_stall && r_state != ST_FIN, !r_ov)
endmodule
`default_nettype wire

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb - digit dominance prefix counter testbench
// Drives (m, n) requests under several radix settings. A directed table
// covers the extremes and the empty range. Random requests follow; every
// result is checked against a table value or a local model of the counts.
// ----------------------------------------------------------------------------
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int    NDIG      = ddpc_pkg::MAX_DIGITS_DEF;
    localparam int    BBITS     = ddpc_pkg::BASE_BITS_DEF;
    localparam int    HOLD_LEN  = 3000;
    localparam int    DRAIN_CYC = 200;
    localparam longint CYC_LIMIT = 20000000;
    localparam int    RAND_PER_PHASE = 62;

    typedef struct packed {
        logic [63:0] hit;
        logic [63:0] dom;
    } t_count;

    typedef struct {
        logic [63:0] m;
        logic [63:0] n;
        bit          known;
        logic [63:0] hit;
        logic [63:0] dom;
    } t_dir_row;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [BBITS-1:0]  i_cfg_data;
    logic              i_in_valid;
    logic              o_in_stall;
    logic [63:0]       i_bound_m;
    logic [63:0]       i_limit_n;
    logic              o_out_valid;
    logic              i_out_stall;
    logic [63:0]       o_hit_count;
    logic [63:0]       o_dominated_count;

    // table values ride along with the payload
    logic              row_known;
    logic [63:0]       row_hit;
    logic [63:0]       row_dom;

    logic [BBITS-1:0]  radix_reg;
    t_count            pending_q[$];
    int                mismatches = 0;
    int                results_seen = 0;
    longint            cycles = 0;
    bit                hold_go = 1'b0;

    digit_dominance_prefix_count u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_bound_m         (i_bound_m),
        .i_limit_n         (i_limit_n),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_hit_count       (o_hit_count),
        .o_dominated_count (o_dominated_count)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // base-p digits of v, low digit first
    function automatic void to_digits(input logic [63:0] p, input logic [63:0] v,
                                      output logic [63:0] dig[NDIG], output int len);
        int i;
        for (i = 0; i < NDIG; i++) dig[i] = '0;
        len = 0;
        if (v == 0) begin
            len = 1;
        end else begin
            while (v != 0 && len < NDIG) begin
                dig[len] = v % p;
                v        = v / p;
                len++;
            end
        end
    endfunction

    // count of x in [0, y] dominated by m digit-wise
    function automatic logic [63:0] dominated_thru(input logic [63:0] p,
                                                   input logic [63:0] m,
                                                   input logic [63:0] y);
        logic [63:0] yd[NDIG];
        logic [63:0] md[NDIG];
        logic [63:0] wt[NDIG+1];
        logic [63:0] acc;
        logic [63:0] pick;
        int          ylen, mlen, len, i;
        to_digits(p, y, yd, ylen);
        to_digits(p, m, md, mlen);
        len   = (ylen > mlen) ? ylen : mlen;
        acc   = '0;
        wt[0] = 64'd1;
        for (i = 0; i < len; i++) wt[i+1] = wt[i] * (md[i] + 64'd1);
        for (i = len - 1; i >= 0; i--) begin
            pick = (yd[i] < md[i] + 64'd1) ? yd[i] : md[i] + 64'd1;
            acc  = acc + pick * wt[i];
            if (yd[i] > md[i]) return acc;
        end
        return acc + 64'd1;
    endfunction

    function automatic t_count predict_counts(input logic [63:0] m, input logic [63:0] n);
        t_count      r;
        logic [63:0] p;
        p = (radix_reg < 2) ? 64'd2 : 64'(radix_reg);
        if (n == 0) begin
            r.hit = '0;
            r.dom = '0;
        end else begin
            r.dom = dominated_thru(p, m, n - 64'd1);
            r.hit = n - r.dom;
        end
        return r;
    endfunction

    // record expectation for every accepted request
    always @(posedge i_clk) begin
        t_count e;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            if (row_known) begin
                e.hit = row_hit;
                e.dom = row_dom;
            end else begin
                e = predict_counts(i_bound_m, i_limit_n);
            end
            pending_q.insert(pending_q.size(), e);
        end
    end

    // check each accepted result against the oldest expectation
    always @(posedge i_clk) begin
        t_count e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (pending_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result hit=%h dom=%h",
                             o_hit_count, o_dominated_count);
            end else begin
                e = pending_q.pop_front();
                if (e.hit !== o_hit_count || e.dom !== o_dominated_count) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp hit=%h dom=%h got hit=%h dom=%h",
                                 e.hit, e.dom, o_hit_count, o_dominated_count);
                end
            end
        end
    end

    // receiver stall: random gaps, plus one long hold-off on request
    always @(posedge i_clk) begin
        static int left = 0;
        static int hold = 0;
        static bit hold_used = 1'b0;
        if (hold_go && !hold_used) begin
            hold_used = 1'b1;
            hold      = HOLD_LEN;
        end
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold > 0) begin
            hold--;
            i_out_stall <= 1'b1;
        end else if (left > 0) begin
            left--;
            i_out_stall <= 1'b1;
        end else if ($urandom_range(0, 3) == 0) begin
            left = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 120)
                                                : $urandom_range(0, 3);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYC_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic send_request(input logic [63:0] m, input logic [63:0] n,
                                input bit known, input logic [63:0] h,
                                input logic [63:0] d, input bit quiet);
        int gap;
        i_in_valid <= 1'b1;
        i_bound_m  <= m;
        i_limit_n  <= n;
        row_known  <= known;
        row_hit    <= h;
        row_dom    <= d;
        do @(posedge i_clk); while (o_in_stall);
        gap = 0;
        if (!quiet && $urandom_range(0, 2) == 0)
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 300)
                                              : $urandom_range(1, 4);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_radix(input logic [BBITS-1:0] v);
        drain_results();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        radix_reg  = v;
        @(posedge i_clk);
    endtask

    function automatic logic [63:0] rand_value(input int bits);
        logic [63:0] v;
        v = {$urandom, $urandom};
        if (bits < 64) v = v & ((64'd1 << bits) - 64'd1);
        return v;
    endfunction

    // random pair; mostly short values so base-2 digit walks stay cheap
    task automatic send_random(input bit quiet);
        logic [63:0] m, n;
        int          bits, kind;
        bits = ($urandom_range(0, 9) == 0) ? 64 : $urandom_range(1, 20);
        m    = rand_value(bits);
        kind = $urandom_range(0, 9);
        case (kind)
            0: n = '0;
            1: n = m;
            2: n = m + 64'd1;
            3: n = m + rand_value(4);
            default: n = rand_value(bits);
        endcase
        send_request(m, n, 1'b0, '0, '0, quiet);
    endtask

    initial begin
        t_dir_row                dir_tab[$];
        logic [BBITS-1:0]        radix_plan[8];
        int                      r, k;
        radix_plan = '{16'd0, 16'd1, 16'd3, 16'd65535, 16'd10, 16'd7, 16'd65521, 16'd2};
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_bound_m   = '0;
        i_limit_n   = '0;
        row_known   = 1'b0;
        row_hit     = '0;
        row_dom     = '0;
        radix_reg   = 16'(ddpc_pkg::BASE_RESET);
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset base 2
        dir_tab = '{
            '{64'd0, 64'd0, 1'b1, 64'd0, 64'd0},
            '{'1, 64'd0, 1'b1, 64'd0, 64'd0},
            '{64'd0, 64'd1, 1'b1, 64'd0, 64'd1},
            '{64'd0, 64'd2, 1'b1, 64'd1, 64'd1},
            '{'1, '1, 1'b1, 64'd0, '1},
            '{'1, 64'd1, 1'b1, 64'd0, 64'd1},
            '{64'd0, '1, 1'b0, '0, '0},
            '{64'h8000_0000_0000_0000, '1, 1'b0, '0, '0},
            '{64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, '0, '0},
            '{64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 1'b0, '0, '0},
            '{64'd5, 64'd6, 1'b0, '0, '0},
            '{64'd6, 64'd7, 1'b0, '0, '0},
            '{64'd1, 64'h8000_0000_0000_0000, 1'b0, '0, '0}
        };
        foreach (dir_tab[i])
            send_request(dir_tab[i].m, dir_tab[i].n, dir_tab[i].known,
                         dir_tab[i].hit, dir_tab[i].dom, 1'b0);

        // random phases, one per radix setting
        for (r = 0; r < 8; r++) begin
            write_radix(radix_plan[r]);
            send_request('1, '1, 1'b0, '0, '0, 1'b0);
            send_request('1, 64'd0, 1'b1, '0, '0, 1'b0);
            if (r == 3) begin
                // long receiver hold-off while requests keep coming
                hold_go = 1'b1;
                for (k = 0; k < 6; k++) send_random(1'b1);
            end
            for (k = 0; k < RAND_PER_PHASE; k++) begin
                send_random(1'b0);
                if (k == RAND_PER_PHASE / 2) drain_results();
            end
        end

        drain_results();
        repeat (DRAIN_CYC) @(posedge i_clk);
        $display("covered %0d results over 9 radix settings incl. 0, 1, 2 and 65535",
                 results_seen);
        $display("with a long output hold-off and sender pauses; %0d mismatches",
                 mismatches);
        if (mismatches == 0 && pending_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
`default_nettype wire
